/* design/ppit_pkg.sv */
package ppit_pkg;

    // Item kinds carried on the input tuser.
    localparam int KIND_BITS = 2;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

    // Register stages in the edge unit, from edge issue to parity update.
    localparam int EDGE_LATENCY = 3;
    localparam int DRAIN_W      = 2;

    typedef struct packed {
        logic clear;   // restart the crossing parity for a new point
        logic valid;   // an edge is presented this cycle
    } t_edge_ctl;

endpackage

/* design/ppit_cell.sv */
module ppit_cell #(
    parameter int CB = 18
) (
    input  logic                 i_clk,
    input  logic                 i_wr,
    input  logic                 i_shift,
    input  logic signed [CB-1:0] i_wr_x,
    input  logic signed [CB-1:0] i_wr_y,
    input  logic signed [CB-1:0] i_nb_x,
    input  logic signed [CB-1:0] i_nb_y,
    output logic signed [CB-1:0] o_x,
    output logic signed [CB-1:0] o_y
);

    logic signed [CB-1:0] r_x;
    logic signed [CB-1:0] r_y;

    // Load a new vertex, or take the neighbor's vertex while the ring rotates.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_shift) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

/* design/ppit_edge.sv */
module ppit_edge #(
    parameter int CB = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppit_pkg::t_edge_ctl  i_ctl,
    input  logic signed [CB-1:0] i_px,
    input  logic signed [CB-1:0] i_py,
    input  logic signed [CB-1:0] i_xi,
    input  logic signed [CB-1:0] i_yi,
    input  logic signed [CB-1:0] i_xj,
    input  logic signed [CB-1:0] i_yj,
    output logic                 o_parity
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] w_px;
    logic signed [DW-1:0] w_py;
    logic signed [DW-1:0] w_xi;
    logic signed [DW-1:0] w_yi;
    logic signed [DW-1:0] w_xj;
    logic signed [DW-1:0] w_yj;
    logic                 w_straddle;
    logic                 w_cross;

    logic                 r1_valid;
    logic signed [DW-1:0] r1_a;
    logic signed [DW-1:0] r1_dy;
    logic signed [DW-1:0] r1_b;
    logic signed [DW-1:0] r1_c;

    logic                 r2_valid;
    logic                 r2_dy_neg;
    logic signed [PW-1:0] r2_p1;
    logic signed [PW-1:0] r2_p2;

    logic                 r_parity;

    assign w_px = $signed({i_px[CB-1], i_px});
    assign w_py = $signed({i_py[CB-1], i_py});
    assign w_xi = $signed({i_xi[CB-1], i_xi});
    assign w_yi = $signed({i_yi[CB-1], i_yi});
    assign w_xj = $signed({i_xj[CB-1], i_xj});
    assign w_yj = $signed({i_yj[CB-1], i_yj});

    // Half-open rule: exactly one endpoint strictly above the query row.
    assign w_straddle = (i_yi > i_py) != (i_yj > i_py);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_ctl.valid && w_straddle;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a      <= w_px - w_xi;
        r1_dy     <= w_yj - w_yi;
        r1_b      <= w_py - w_yi;
        r1_c      <= w_xj - w_xi;
        r2_p1     <= r1_a * r1_dy;
        r2_p2     <= r1_b * r1_c;
        r2_dy_neg <= r1_dy[DW-1];
    end

    // Crossing strictly left of the point: (px-xi)*dy vs (py-yi)*(xj-xi), sign of dy.
    assign w_cross = r2_dy_neg ? (r2_p1 < r2_p2) : (r2_p1 > r2_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_ctl.clear) begin
            r_parity <= 1'b0;
        end else if (r2_valid && w_cross) begin
            r_parity <= ~r_parity;
        end
    end

    assign o_parity = r_parity;

endmodule

/* design/polygon_point_inside_test_unit.sv */
// Even-odd point-in-polygon unit. Vertices sit one per cell in a ring of
// MAX_VERTICES cells; the polygon closes from the last vertex to the first.
// A clear or an append request writes its result straight to the result
// registers. A query rotates the ring one cell per cycle past a single
// pipelined edge unit, which evaluates one edge per cycle, and then waits
// for the edge unit to drain. One request is in work at a time; a second
// result register lets the next request in while a result waits on the
// master side. An append to a full store is dropped and flagged; a query on
// fewer than three vertices answers outside.
module polygon_point_inside_test_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 18,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1),
    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((CNT_W + 2 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,  // coord_x, coord_y
    input  logic [ppit_pkg::KIND_BITS-1:0] s_axis_tuser,  // kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata   // inside_res, vertex_count, dropped
);

    localparam int CB = COORD_BITS;
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
    localparam logic [ppit_pkg::DRAIN_W-1:0] DRAIN_LAST =
        ppit_pkg::DRAIN_W'(ppit_pkg::EDGE_LATENCY - 1);

    logic [1:0]                   r_state;
    logic [CNT_W-1:0]             r_step;
    logic [ppit_pkg::DRAIN_W-1:0] r_drain;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic signed [CB-1:0]         r_px;
    logic signed [CB-1:0]         r_py;
    logic signed [CB-1:0]         r_prev_x;
    logic signed [CB-1:0]         r_prev_y;
    logic signed [CB-1:0]         r_first_x;
    logic signed [CB-1:0]         r_first_y;
    logic                         r_out_valid;
    logic                         r_out_inside;
    logic [CNT_W-1:0]             r_out_count;
    logic                         r_out_dropped;
    logic                         r_hold_valid;
    logic                         r_hold_inside;
    logic [CNT_W-1:0]             r_hold_count;
    logic                         r_hold_dropped;

    logic signed [CB-1:0] w_x [MAX_VERTICES];
    logic signed [CB-1:0] w_y [MAX_VERTICES];
    logic signed [CB-1:0] w_in_x;
    logic signed [CB-1:0] w_in_y;
    logic signed [CB-1:0] w_xj;
    logic signed [CB-1:0] w_yj;
    logic                 w_in_acc;
    logic                 w_append;
    logic                 w_full;
    logic                 w_run;
    logic                 w_shift;
    logic                 w_close;
    logic                 w_done;
    logic                 w_parity;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_push_inside;
    logic [CNT_W-1:0]     w_push_count;
    logic                 w_push_dropped;
    ppit_pkg::t_edge_ctl  w_ctl;

    assign w_in_x = $signed(s_axis_tdata[CB-1:0]);
    assign w_in_y = $signed(s_axis_tdata[2*CB-1:CB]);

    // Take a request only while idle and a result slot is free or being freed.
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_hold_valid || m_axis_tready);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_MAX);
    assign w_append      = w_in_acc && (s_axis_tuser == ppit_pkg::KIND_APPEND);

    // Rotate the ring by MAX_VERTICES cells so it ends where it started.
    assign w_run   = (r_state == ST_RUN);
    assign w_shift = w_run && (r_step != CNT_MAX);
    assign w_close = (r_step == r_count);
    assign w_done  = (r_state == ST_DRAIN) && (r_drain == DRAIN_LAST);

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
            localparam int NB = (k + 1) % MAX_VERTICES;
            ppit_cell #(
                .CB(CB)
            ) u_cell (
                .i_clk   (i_clk),
                .i_wr    (w_append && (r_count == CNT_W'(k))),
                .i_shift (w_shift),
                .i_wr_x  (w_in_x),
                .i_wr_y  (w_in_y),
                .i_nb_x  (w_x[NB]),
                .i_nb_y  (w_y[NB]),
                .o_x     (w_x[k]),
                .o_y     (w_y[k])
            );
        end
    endgenerate

    // Head cell holds vertex r_step; the closing edge returns to the saved first vertex.
    assign w_xj = w_close ? r_first_x : w_x[0];
    assign w_yj = w_close ? r_first_y : w_y[0];

    assign w_ctl.clear = w_in_acc && (s_axis_tuser == ppit_pkg::KIND_QUERY);
    assign w_ctl.valid = w_run && (r_step != '0) && (r_step <= r_count);

    ppit_edge #(
        .CB(CB)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_xi     (r_prev_x),
        .i_yi     (r_prev_y),
        .i_xj     (w_xj),
        .i_yj     (w_yj),
        .o_parity (w_parity)
    );

    always_comb begin
        n_count = r_count;
        if (w_in_acc) begin
            unique case (s_axis_tuser)
                ppit_pkg::KIND_CLEAR:  n_count = '0;
                ppit_pkg::KIND_APPEND: n_count = w_full ? r_count : r_count + 1'b1;
                default:               n_count = r_count;
            endcase
        end
    end

    assign w_pop          = r_out_valid && m_axis_tready;
    assign w_push         = (w_in_acc && !w_ctl.clear) || w_done;
    assign w_push_inside  = w_done ? w_parity : 1'b0;
    assign w_push_count   = n_count;
    assign w_push_dropped = w_append && w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_drain      <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_ctl.clear) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_step == CNT_MAX) begin
                        r_state <= ST_DRAIN;
                        r_drain <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_drain <= r_drain + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // Advance the held result to the output; park a new one behind a waiting result.
            if (!r_out_valid || w_pop) begin
                r_out_valid  <= r_hold_valid || w_push;
                r_hold_valid <= r_hold_valid && w_push;
            end else if (w_push) begin
                r_hold_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_px <= w_in_x;
            r_py <= w_in_y;
        end
        if (w_run) begin
            r_prev_x <= w_x[0];
            r_prev_y <= w_y[0];
        end
        if (w_run && (r_step == '0)) begin
            r_first_x <= w_x[0];
            r_first_y <= w_y[0];
        end
        if (!r_out_valid || w_pop) begin
            if (r_hold_valid) begin
                r_out_inside  <= r_hold_inside;
                r_out_count   <= r_hold_count;
                r_out_dropped <= r_hold_dropped;
            end else if (w_push) begin
                r_out_inside  <= w_push_inside;
                r_out_count   <= w_push_count;
                r_out_dropped <= w_push_dropped;
            end
        end
        if (w_push) begin
            r_hold_inside  <= w_push_inside;
            r_hold_count   <= w_push_count;
            r_hold_dropped <= w_push_dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_dropped, r_out_count, r_out_inside});

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("stored vertex count beyond capacity");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> (r_state == ST_RUN) && (r_step == '0))
        else $error("query request did not start a ring rotation");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dropped) |-> (r_out_count == CNT_MAX))
        else $error("drop flagged while store has room");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_IDLE || $past(r_state) == ST_DRAIN))
        else $error("result loaded in the middle of a rotation");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    import ppit_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 18;
    localparam int CNT_W        = 7;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 16;
    localparam int COORD_MAX    = 131071;
    localparam int COORD_MIN    = -131072;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    localparam int TARGET_REQUESTS = 1600;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int REPORT_LIMIT    = 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic             in_poly;
        logic [CNT_W-1:0] vertex_count;
        logic             dropped;
    } answer_t;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_LONG} rx_mode_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;  // coord_x, coord_y
    logic [KIND_BITS-1:0] s_axis_tuser  = '0;  // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // inside_res, vertex_count, dropped

    polygon_point_inside_test_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Polygon as the block should hold it
    coord_t ring_x [MAX_VERTICES];
    coord_t ring_y [MAX_VERTICES];
    int     ring_len = 0;

    answer_t pending_answers[$];

    int errors          = 0;
    int requests_sent   = 0;
    int answers_checked = 0;
    int queries_sent    = 0;
    int inside_answers  = 0;
    int drops_predicted = 0;
    int unused_sent     = 0;
    int burst_left      = 0;

    // Edge counts when exactly one endpoint is above the row and the crossing
    // lies strictly left of px; cross-multiply instead of dividing by dy.
    function automatic bit crosses_left(longint xi, longint yi, longint xj, longint yj,
                                        longint px, longint py);
        longint dy, lhs, rhs;
        if ((yi > py) == (yj > py))
            return 1'b0;
        dy  = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (py - yi) * (xj - xi);
        return (dy > 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    function automatic answer_t answer_request(logic [KIND_BITS-1:0] kind, coord_t x, coord_t y);
        answer_t a;
        int      hits;
        int      j;
        a    = '0;
        hits = 0;
        case (kind)
            KIND_CLEAR: ring_len = 0;
            KIND_APPEND: begin
                if (ring_len < MAX_VERTICES) begin
                    ring_x[ring_len] = x;
                    ring_y[ring_len] = y;
                    ring_len++;
                end else begin
                    a.dropped = 1'b1;
                end
            end
            KIND_QUERY: begin
                for (int i = 0; i < ring_len; i++) begin
                    j = (i + 1 == ring_len) ? 0 : i + 1;
                    if (crosses_left(ring_x[i], ring_y[i], ring_x[j], ring_y[j], x, y))
                        hits++;
                end
                a.in_poly = hits[0];
            end
            default: ;
        endcase
        a.vertex_count = ring_len[CNT_W-1:0];
        return a;
    endfunction

    function automatic coord_t coord_any();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t coord_near(int center, int span);
        int v;
        v = center + int'($urandom_range(0, 2 * span)) - span;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return coord_t'(v);
    endfunction

    task automatic log_mismatch(string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic send_request(logic [KIND_BITS-1:0] kind, coord_t x, coord_t y);
        int      gap;
        answer_t a;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(8, 20);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= IN_W'({$urandom, $urandom});
                s_axis_tuser  <= KIND_BITS'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 2 * COORD_W){1'b0}}, y, x};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        a = answer_request(kind, x, y);
        pending_answers.push_back(a);
        burst_left--;
        requests_sent++;
        if (kind == KIND_QUERY) begin
            queries_sent++;
            inside_answers += a.in_poly;
        end
        if (kind == KIND_UNUSED)
            unused_sent++;
        drops_predicted += a.dropped;
    endtask

    // Empty store, one and two vertices, and the unused kind
    task automatic test_degenerate_polygons();
        send_request(KIND_CLEAR, 0, 0);
        send_request(KIND_QUERY, 0, 0);
        send_request(KIND_APPEND, COORD_MIN, COORD_MIN);
        send_request(KIND_QUERY, 0, 0);
        send_request(KIND_APPEND, COORD_MAX, COORD_MIN);
        send_request(KIND_QUERY, 0, COORD_MIN + 1);
        send_request(KIND_UNUSED, COORD_MAX, COORD_MIN);
        send_request(KIND_UNUSED, -1, -1);
    endtask

    // Complete the full-range square and probe its interior, a corner and its edges
    task automatic test_full_extent_square();
        send_request(KIND_APPEND, COORD_MAX, COORD_MAX);
        send_request(KIND_APPEND, COORD_MIN, COORD_MAX);
        send_request(KIND_QUERY, 0, 0);
        send_request(KIND_QUERY, COORD_MIN, 0);
        send_request(KIND_QUERY, COORD_MAX, 0);
        send_request(KIND_QUERY, 0, COORD_MAX);
        send_request(KIND_QUERY, COORD_MIN, COORD_MIN);
        send_request(KIND_QUERY, -1, -1);
    endtask

    task automatic test_horizontal_base();
        send_request(KIND_CLEAR, COORD_MAX, COORD_MIN);
        send_request(KIND_APPEND, 0, 0);
        send_request(KIND_APPEND, 1000, 0);
        send_request(KIND_APPEND, 500, 1000);
        send_request(KIND_QUERY, 500, 0);
        send_request(KIND_QUERY, 500, 500);
        send_request(KIND_QUERY, 500, 1000);
        send_request(KIND_QUERY, -5, 0);
        send_request(KIND_QUERY, 750, 500);
    endtask

    task automatic test_store_full();
        send_request(KIND_CLEAR, coord_any(), coord_any());
        repeat (MAX_VERTICES) send_request(KIND_APPEND, coord_any(), coord_any());
        repeat (3) send_request(KIND_APPEND, coord_any(), coord_any());
        repeat (4) send_request(KIND_QUERY, coord_any(), coord_any());
        send_request(KIND_UNUSED, coord_any(), coord_any());
        send_request(KIND_QUERY, 0, 0);
        send_request(KIND_CLEAR, coord_any(), coord_any());
    endtask

    // Build a polygon inside a random box, then query around it
    task automatic run_polygon_session(bit fresh);
        coord_t vx[$], vy[$];
        coord_t qx, qy;
        int     center_x, center_y, span, n_vertices, n_queries, k, m, mid;
        center_x = int'(coord_any());
        center_y = int'(coord_any());
        case ($urandom_range(0, 3))
            0:       span = $urandom_range(1, 64);
            1:       span = $urandom_range(65, 4096);
            2:       span = $urandom_range(4097, 40000);
            default: span = COORD_MAX;
        endcase
        case ($urandom_range(0, 19))
            0:       n_vertices = $urandom_range(0, 2);
            1:       n_vertices = $urandom_range(60, 70);
            default: n_vertices = $urandom_range(3, 10);
        endcase
        if (fresh)
            send_request(KIND_CLEAR, coord_any(), coord_any());
        repeat (n_vertices) begin
            qx = coord_near(center_x, span);
            qy = coord_near(center_y, span);
            vx.push_back(qx);
            vy.push_back(qy);
            send_request(KIND_APPEND, qx, qy);
        end
        n_queries = $urandom_range(2, 8);
        repeat (n_queries) begin
            qx = coord_near(center_x, span);
            qy = coord_near(center_y, span);
            if (vx.size() != 0) begin
                k = $urandom_range(0, vx.size() - 1);
                m = (k + 1) % vx.size();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: begin
                        // same row as a vertex
                        qy = vy[k];
                    end
                    4, 5: qx = vx[k];
                    6, 7, 8: begin
                        qx = vx[k];
                        qy = vy[k];
                    end
                    9, 10, 11: begin
                        mid = (int'(vx[k]) + int'(vx[m])) / 2;
                        qx  = coord_t'(mid);
                        mid = (int'(vy[k]) + int'(vy[m])) / 2;
                        qy  = coord_t'(mid);
                    end
                    12, 13: begin
                        qx = coord_any();
                        qy = coord_any();
                    end
                    default: ;
                endcase
            end
            send_request(KIND_QUERY, qx, qy);
        end
    endtask

    task automatic test_random_polygons();
        int pick;
        while (requests_sent < TARGET_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                run_polygon_session(1'b1);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 5))
                    send_request(KIND_BITS'($urandom_range(0, 3)), coord_any(), coord_any());
            end else begin
                // extend whatever is stored, no clear first
                run_polygon_session(1'b0);
            end
        end
    endtask

    // Receiver back-pressure, switching pattern every so often
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode_left  <= 0;
            rx_hold_left  <= 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(16, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (rx_hold_left == 0) begin
                        m_axis_tready <= ~m_axis_tready;
                        rx_hold_left  <= $urandom_range(1, 30);
                    end else begin
                        rx_hold_left <= rx_hold_left - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_answers
        answer_t want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.in_poly      = m_axis_tdata[0];
            got.vertex_count = m_axis_tdata[CNT_W:1];
            got.dropped      = m_axis_tdata[CNT_W+1];
            answers_checked++;
            if (pending_answers.size() == 0) begin
                log_mismatch($sformatf("result with no request pending (count %0d)",
                                       got.vertex_count));
            end else begin
                want = pending_answers.pop_front();
                if (got.in_poly !== want.in_poly)
                    log_mismatch($sformatf("answer %0d inside_res: expected %0d, got %0d",
                                           answers_checked, want.in_poly, got.in_poly));
                if (got.vertex_count !== want.vertex_count)
                    log_mismatch($sformatf("answer %0d vertex_count: expected %0d, got %0d",
                                           answers_checked, want.vertex_count,
                                           got.vertex_count));
                if (got.dropped !== want.dropped)
                    log_mismatch($sformatf("answer %0d dropped: expected %0d, got %0d",
                                           answers_checked, want.dropped, got.dropped));
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Stalled for %0d cycles with %0d answers outstanding",
                     quiet_cycles, pending_answers.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_degenerate_polygons();
        test_full_extent_square();
        test_horizontal_base();
        test_store_full();
        test_random_polygons();

        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d point queries (%0d inside), %0d unused-kind items,",
                 requests_sent, queries_sent, inside_answers, unused_sent);
        $display("%0d appends refused on a full store; %0d answers checked, %0d mismatches",
                 drops_predicted, answers_checked, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
design/ppit_pkg.sv
design/ppit_cell.sv
design/ppit_edge.sv
design/polygon_point_inside_test_unit.sv
tb/tb_top.sv
